[src/aes128_cbc_encrypt_block_macros.svh]
// Assertion macros for the AES-128 CBC encrypt block checker.
// Included by the checker file; depends on nothing else.
`ifndef AES128_CBC_ENCRYPT_BLOCK_MACROS_SVH
`define AES128_CBC_ENCRYPT_BLOCK_MACROS_SVH
// Assert that an antecedent implies a consequent on the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
// Assert that an expression holds in the same cycle.
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`endif

[src/aes_pkg.sv]
// Shared types, constants and functions for the AES-128 CBC encrypt block.
// No dependencies.
package aes_pkg;

   localparam int DataWidth  = 64;
   localparam int CountWidth = 5;
   localparam int CsrIdxWidth = 2;
   localparam int NumRounds  = 10;
   localparam int RoundWidth = 4;
   localparam logic [7:0] GfPoly = 8'h1B;
   localparam logic [7:0] RconInit = 8'h01;

   localparam logic [CsrIdxWidth-1:0] CsrKeyHi = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrKeyLo = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CsrIvHi  = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CsrIvLo  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [DataWidth-1:0] data_hi;
      logic [DataWidth-1:0] data_lo;
      logic [CountWidth-1:0] byte_count;
      logic first_block;
   } req_type;

   typedef struct packed {
      logic [DataWidth-1:0] cipher_hi;
      logic [DataWidth-1:0] cipher_lo;
   } rsp_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] r;
      case (a)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] gf_double(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? GfPoly : 8'h00);
   endfunction

endpackage

[src/aes_if.sv]
// Valid/ready channel interface carrying one payload type.
// Depends on aes_pkg for the payload types.
interface aes_if #(
   parameter type payload_type = aes_pkg::req_type
) ();
   logic valid;
   logic ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[src/aes128_cbc_encrypt_block.sv]
// AES-128 CBC encryption top level: one round engine, key schedule and sequencer.
// Depends on aes_pkg and aes_if.
//
//  channel | dir | payload
//  req     | in  | data_hi, data_lo, byte_count, first_block
//  rsp     | out | cipher_hi, cipher_lo
//  csr     | in  | key_hi, key_lo, iv_hi, iv_lo (index 0..3)
//
// A request accepted at one edge is loaded with the initial AddRoundKey, then
// runs its ten rounds through the shared round unit (SubBytes, ShiftRows,
// MixColumns except in the last round, AddRoundKey, next round key); the
// response is then valid and is held while stalled. A new request is taken
// no earlier than the cycle after the response has been taken. Reset is
// synchronous, active high, and clears control state, the chaining value and
// the key and IV registers.
module aes128_cbc_encrypt_block (
   input  logic clock,
   input  logic reset,
   aes_if.sink   req,
   aes_if.source rsp,
   input  logic csr_we,
   input  logic [aes_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [aes_pkg::DataWidth-1:0]   csr_wdata
);

   aes_pkg::state_type state_ff, state_in;
   logic [127:0] key_ff, iv_ff, chain_ff, blk_ff, blk_in, rk_ff, rk_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [aes_pkg::RoundWidth-1:0] round_ff, round_in;
   logic [127:0] plain, chv, masked, sub_sh, mixed;
   logic [31:0]  tw;
   logic         req_fire, rsp_fire, last;

   assign req_fire = req.valid && req.ready;
   assign rsp_fire = rsp.valid && rsp.ready;
   assign last = (round_ff == 4'(aes_pkg::NumRounds - 1));

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         iv_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            aes_pkg::CsrKeyHi: key_ff[127:64] <= csr_wdata;
            aes_pkg::CsrKeyLo: key_ff[63:0]   <= csr_wdata;
            aes_pkg::CsrIvHi:  iv_ff[127:64]  <= csr_wdata;
            aes_pkg::CsrIvLo:  iv_ff[63:0]    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Mask and chain the plaintext
   assign plain = {req.payload.data_hi, req.payload.data_lo};
   assign chv = req.payload.first_block ? iv_ff : chain_ff;
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         masked[127-8*i -: 8] = (5'(i) < req.payload.byte_count) ?
            (plain[127-8*i -: 8] ^ chv[127-8*i -: 8]) : 8'h00;
      end
   end

   // Shared round unit: SubBytes and ShiftRows, then MixColumns
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            sub_sh[127-8*(4*c+r) -: 8] =
               aes_pkg::sbox(blk_ff[127-8*(4*((c+r)%4)+r) -: 8]);
         end
      end
      for (int c = 0; c < 4; c++) begin
         logic [7:0] a0, a1, a2, a3, al;
         a0 = sub_sh[127-32*c -: 8];
         a1 = sub_sh[119-32*c -: 8];
         a2 = sub_sh[111-32*c -: 8];
         a3 = sub_sh[103-32*c -: 8];
         al = a0 ^ a1 ^ a2 ^ a3;
         mixed[127-32*c -: 8] = a0 ^ al ^ aes_pkg::gf_double(a0 ^ a1);
         mixed[119-32*c -: 8] = a1 ^ al ^ aes_pkg::gf_double(a1 ^ a2);
         mixed[111-32*c -: 8] = a2 ^ al ^ aes_pkg::gf_double(a2 ^ a3);
         mixed[103-32*c -: 8] = a3 ^ al ^ aes_pkg::gf_double(a3 ^ a0);
      end
   end

   // Key schedule step
   always_comb begin
      tw = {aes_pkg::sbox(rk_ff[23:16]) ^ rcon_ff, aes_pkg::sbox(rk_ff[15:8]),
            aes_pkg::sbox(rk_ff[7:0]), aes_pkg::sbox(rk_ff[31:24])};
      rk_in[127:96] = rk_ff[127:96] ^ tw;
      rk_in[95:64]  = rk_ff[95:64] ^ rk_in[127:96];
      rk_in[63:32]  = rk_ff[63:32] ^ rk_in[95:64];
      rk_in[31:0]   = rk_ff[31:0] ^ rk_in[63:32];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         aes_pkg::ST_IDLE:  if (req_fire) state_in = aes_pkg::ST_ROUND;
         aes_pkg::ST_ROUND: if (last) state_in = aes_pkg::ST_DONE;
         aes_pkg::ST_DONE:  if (rsp_fire) state_in = aes_pkg::ST_IDLE;
         default: state_in = aes_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath updates
   always_comb begin
      req.ready = 1'b0;
      rsp.valid = 1'b0;
      blk_in = blk_ff;
      rcon_in = rcon_ff;
      round_in = round_ff;
      case (state_ff)
         aes_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            blk_in = masked ^ key_ff;
            rcon_in = aes_pkg::RconInit;
            round_in = '0;
         end
         aes_pkg::ST_ROUND: begin
            blk_in = (last ? sub_sh : mixed) ^ rk_in;
            rcon_in = aes_pkg::gf_double(rcon_ff);
            round_in = round_ff + 4'd1;
         end
         aes_pkg::ST_DONE: rsp.valid = 1'b1;
         default: ;
      endcase
   end

   assign rsp.payload.cipher_hi = blk_ff[127:64];
   assign rsp.payload.cipher_lo = blk_ff[63:0];

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aes_pkg::ST_IDLE;
         rcon_ff  <= aes_pkg::RconInit;
         round_ff <= '0;
         chain_ff <= '0;
      end else begin
         state_ff <= state_in;
         rcon_ff  <= rcon_in;
         round_ff <= round_in;
         if (state_ff == aes_pkg::ST_ROUND && last) chain_ff <= blk_in;
      end
   end

   // Hold payload registers
   always_ff @(posedge clock) begin
      if (state_ff != aes_pkg::ST_DONE) blk_ff <= blk_in;
      if (state_ff == aes_pkg::ST_IDLE) rk_ff <= key_ff;
      else if (state_ff == aes_pkg::ST_ROUND) rk_ff <= rk_in;
   end

endmodule

[src/aes128_cbc_encrypt_block_checker.sv]
// Port-level checker for the AES-128 CBC encrypt block, with its bind.
// Depends on aes_pkg and the macro header.
`include "aes128_cbc_encrypt_block_macros.svh"
module aes_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [aes_pkg::DataWidth-1:0] cipher_hi
);
   // A request is never taken while a response waits
   `ASSERT_NOW(a_no_overlap, clock, reset, rsp_valid, !req_ready, "ready with pending response")
   // An accepted request leaves the block busy next cycle
   `ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready && !rsp_valid, "not busy")
   // A stalled response holds its data
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(cipher_hi), "dropped")
   // A taken response returns to idle
   `ASSERT_NEXT(a_idle, clock, reset, rsp_valid && rsp_ready, req_ready && !rsp_valid, "no idle")
endmodule

bind aes128_cbc_encrypt_block aes_checker u_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .cipher_hi(rsp.payload.cipher_hi)
);

[verif/aes128_cbc_encrypt_block_tb.sv]
// Self-checking testbench for the AES-128 CBC encrypt block.
// Depends on aes_pkg, aes_if and the aes128_cbc_encrypt_block top level.
`timescale 1ns / 100ps

module aes128_cbc_encrypt_block_tb;

   localparam int WatchdogLimit = 4000;
   localparam int DrainCycles   = 30;
   localparam int NumRandom     = 950;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [aes_pkg::CsrIdxWidth-1:0] csr_index = '0;
   logic [aes_pkg::DataWidth-1:0]   csr_wdata = '0;

   aes_if #(.payload_type(aes_pkg::req_type)) req ();
   aes_if #(.payload_type(aes_pkg::rsp_type)) rsp ();

   aes128_cbc_encrypt_block dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // Predictor state: registers and the chaining value
   logic [aes_pkg::DataWidth-1:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
   logic [aes_pkg::DataWidth-1:0] chain_hi_q, chain_lo_q;
   aes_pkg::rsp_type cipher_queue[$];
   int  errors = 0;
   int  idle_cycles = 0;
   int  req_sent = 0;
   int  rsp_seen = 0;
   bit  hold_rsp = 1'b0;

   // S-box table, filled once from the standard values
   logic [7:0] sub_bytes_tab[256];
   initial begin
      sub_bytes_tab = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
   end

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // Encrypt one request and advance the chaining value
   function automatic aes_pkg::rsp_type encrypt_block(input aes_pkg::req_type r);
      logic [7:0] st[16], kb[16], ch[16], tmp[16];
      logic [7:0] rcon, t0, t1, t2, t3, a0, a1, a2, a3, all;
      logic [127:0] pt, cv, kv, out;
      aes_pkg::rsp_type res;
      pt = {r.data_hi, r.data_lo};
      cv = r.first_block ? {iv_hi_q, iv_lo_q} : {chain_hi_q, chain_lo_q};
      kv = {key_hi_q, key_lo_q};
      for (int i = 0; i < 16; i++) begin
         st[i] = (i < r.byte_count) ? pt[127-8*i -: 8] ^ cv[127-8*i -: 8] : 8'h00;
         kb[i] = kv[127-8*i -: 8];
         st[i] ^= kb[i];
      end
      rcon = 8'h01;
      for (int rnd = 0; rnd < 10; rnd++) begin
         t0 = sub_bytes_tab[kb[13]] ^ rcon;
         t1 = sub_bytes_tab[kb[14]];
         t2 = sub_bytes_tab[kb[15]];
         t3 = sub_bytes_tab[kb[12]];
         kb[0] ^= t0; kb[1] ^= t1; kb[2] ^= t2; kb[3] ^= t3;
         for (int i = 4; i < 16; i++) kb[i] ^= kb[i-4];
         rcon = xtime(rcon);
         for (int c = 0; c < 4; c++)
            for (int rw = 0; rw < 4; rw++)
               tmp[4*c+rw] = sub_bytes_tab[st[4*((c+rw)%4)+rw]];
         st = tmp;
         if (rnd < 9) begin
            for (int c = 0; c < 4; c++) begin
               a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
               all = a0 ^ a1 ^ a2 ^ a3;
               st[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
               st[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
               st[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
               st[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) st[i] ^= kb[i];
      end
      for (int i = 0; i < 16; i++) out[127-8*i -: 8] = st[i];
      res.cipher_hi = out[127:64];
      res.cipher_lo = out[63:0];
      chain_hi_q = res.cipher_hi;
      chain_lo_q = res.cipher_lo;
      return res;
   endfunction

   task automatic write_csr(input logic [aes_pkg::CsrIdxWidth-1:0] idx,
                            input logic [aes_pkg::DataWidth-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         aes_pkg::CsrKeyHi: key_hi_q = val;
         aes_pkg::CsrKeyLo: key_lo_q = val;
         aes_pkg::CsrIvHi:  iv_hi_q = val;
         default:           iv_lo_q = val;
      endcase
   endtask

   // Drop the request line and wait until every response has come back
   task automatic wait_drained();
      req.valid <= 1'b0;
      while (cipher_queue.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Offer one request, after a random gap when gaps is set; hold it until accepted.
   // Keep valid high into the next request when it follows at once.
   task automatic send_request(input aes_pkg::req_type r, input bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.payload <= r;
      do @(posedge clock); while (!req.ready);
      cipher_queue.push_back(encrypt_block(r));
      req_sent++;
   endtask

   function automatic aes_pkg::req_type random_request(input int mode);
      aes_pkg::req_type r;
      r.data_hi = {$urandom, $urandom};
      r.data_lo = {$urandom, $urandom};
      case (mode)
         0: r.byte_count = 5'd16;
         1: r.byte_count = 5'($urandom_range(1, 16));
         default: r.byte_count = 5'($urandom);
      endcase
      r.first_block = ($urandom_range(0, 5) == 0);
      return r;
   endfunction

   // Receiver: random stalls, plus a long hold while hold_rsp is set
   initial begin
      int wait_cnt;
      rsp.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp.ready <= 1'b0;
            repeat (200) @(posedge clock);
            hold_rsp = 1'b0;
         end
         wait_cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
         if (wait_cnt > 0) begin
            rsp.ready <= 1'b0;
            repeat (wait_cnt - 1) @(posedge clock);
            @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
         rsp.ready <= 1'b0;
      end
   end

   // Compare each response with the oldest expected ciphertext
   always @(posedge clock) begin
      aes_pkg::rsp_type exp_c;
      if (!reset && rsp.valid && rsp.ready) begin
         rsp_seen++;
         if (cipher_queue.size() == 0) begin
            $error("unexpected response %h", rsp.payload);
            errors++;
         end else begin
            exp_c = cipher_queue.pop_front();
            if (rsp.payload.cipher_hi !== exp_c.cipher_hi) begin
               $error("cipher_hi expected %h actual %h", exp_c.cipher_hi, rsp.payload.cipher_hi);
               errors++;
            end
            if (rsp.payload.cipher_lo !== exp_c.cipher_lo) begin
               $error("cipher_lo expected %h actual %h", exp_c.cipher_lo, rsp.payload.cipher_lo);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles with no accepted request or response
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("watchdog expired: %0d sent, %0d received", req_sent, rsp_seen);
         $display("aes128_cbc_encrypt_block test failed");
         $finish;
      end
   end

   // Directed table: data_hi, data_lo, byte_count, first_block
   aes_pkg::req_type directed[] = '{
      '{64'h0, 64'h0, 5'd16, 1'b1},
      '{64'h0, 64'h0, 5'd16, 1'b0},
      '{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd16, 1'b1},
      '{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd1, 1'b0},
      '{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd0, 1'b0},
      '{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd31, 1'b0},
      '{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd17, 1'b1},
      '{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 5'd8, 1'b0},
      '{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 5'd9, 1'b0},
      '{64'h00112233445566ff, 64'h8899aabbccddeeff, 5'd15, 1'b1}
   };

   initial begin
      aes_pkg::req_type r;
      int mode;
      req.valid = 1'b0;
      req.payload = '0;
      key_hi_q = '0; key_lo_q = '0; iv_hi_q = '0; iv_lo_q = '0;
      chain_hi_q = '0; chain_lo_q = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero key and IV after reset: all-zero block encrypts to a known value
      send_request('{64'h0, 64'h0, 5'd16, 1'b0}, 1'b0);
      cipher_queue[cipher_queue.size()-1] = '{64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e};
      wait_drained();

      // Standard test vector key, IV zero, then all-ones extremes
      write_csr(aes_pkg::CsrKeyHi, 64'h0001020304050607);
      write_csr(aes_pkg::CsrKeyLo, 64'h08090a0b0c0d0e0f);
      write_csr(aes_pkg::CsrIvHi, 64'h0);
      write_csr(aes_pkg::CsrIvLo, 64'h0);
      send_request('{64'h0011223344556677, 64'h8899aabbccddeeff, 5'd16, 1'b1}, 1'b0);
      cipher_queue[cipher_queue.size()-1] = '{64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a};
      foreach (directed[i]) send_request(directed[i], 1'b1);
      wait_drained();
      write_csr(aes_pkg::CsrKeyHi, '1);
      write_csr(aes_pkg::CsrKeyLo, '1);
      write_csr(aes_pkg::CsrIvHi, '1);
      write_csr(aes_pkg::CsrIvLo, '1);
      foreach (directed[i]) send_request(directed[i], 1'b1);
      wait_drained();

      // Random requests in phases with new keys and IVs
      for (int ph = 0; ph < 5; ph++) begin
         write_csr(aes_pkg::CsrKeyHi, {$urandom, $urandom});
         write_csr(aes_pkg::CsrKeyLo, {$urandom, $urandom});
         write_csr(aes_pkg::CsrIvHi, {$urandom, $urandom});
         write_csr(aes_pkg::CsrIvLo, {$urandom, $urandom});
         if (ph == 1) hold_rsp = 1'b1;
         for (int n = 0; n < NumRandom / 5; n++) begin
            mode = $urandom_range(0, 9);
            r = random_request(mode < 6 ? 0 : (mode < 9 ? 1 : 2));
            send_request(r, (ph != 1) && ($urandom_range(0, 4) != 0));
            // pause until everything in flight has come back
            if (n == 50) wait_drained();
         end
         wait_drained();
      end

      wait_drained();
      $display("sent %0d requests across 8 key/IV settings, received %0d responses",
         req_sent, rsp_seen);
      if (errors == 0 && cipher_queue.size() == 0)
         $display("aes128_cbc_encrypt_block test passed");
      else
         $display("aes128_cbc_encrypt_block test failed");
      $finish;
   end
endmodule
